FILE: hw/rtl/sct_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sct_pkg: shared types and constants
// This package holds the constants, the rounding helper and the queue entry
// type that the sine and cosine unit uses.
// ----------------------------------------------------------------------------
package sct_pkg;

    localparam int ANGLE_W = 40;
    localparam int VALUE_W = 32;
    localparam int TERMS_W = 4;

    // Angle constants in Q.56.
    localparam logic signed [63:0] PI_Q56         = 64'sh03243F6A8885A309;
    localparam logic signed [63:0] TWO_PI_Q56     = 64'sh06487ED5110B4612;
    localparam logic signed [63:0] HALF_PI_Q56    = 64'sh01921FB54442D184;
    localparam logic signed [63:0] QUARTER_PI_Q56 = 64'sh00C90FDAA22168C2;
    localparam logic [23:0]        INV_TWO_PI_Q24 = 24'd2670177;
    localparam logic signed [33:0] ONE_Q31        = 34'sh080000000;
    localparam logic signed [33:0] OUT_LIMIT      = 34'sh040000000;

    localparam logic REQ_SIN = 1'b0;
    localparam logic REQ_COS = 1'b1;

    // Word passed from the front part to the series part.
    typedef struct packed {
        logic               cosine;
        logic               negate;
        logic signed [63:0] arg;
    } sct_job_t;

    // Round to nearest, ties away from zero, right shift.
    function automatic logic signed [95:0] rnd_shift(input logic signed [95:0] v,
                                                     input int sh);
        logic [95:0] m;
        logic [95:0] r;
        begin
            m = v[95] ? 96'(-v) : 96'(v);
            r = (m + (96'd1 << (sh - 1))) >> sh;
            return v[95] ? -$signed(r) : $signed(r);
        end
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/sct_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sct_in_if / sct_out_if: valid-ready channels
// Input channel carries the selector and angle; output channel the result.
// ----------------------------------------------------------------------------
interface sct_in_if;
    logic                             valid;
    logic                             ready;
    logic                             req_type;
    logic signed [sct_pkg::ANGLE_W-1:0] angle;
    modport source (output valid, output req_type, output angle, input ready);
    modport sink (input valid, input req_type, input angle, output ready);
endinterface

interface sct_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [sct_pkg::VALUE_W-1:0] value;
    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/sct_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sct_front: range reduction and folding
// Three stages: quotient estimate, remainder, fold into [-pi/4, pi/4].
// The stages advance when the next stage can take a word.
// ----------------------------------------------------------------------------
module sct_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 req_type,
    input  wire logic [sct_pkg::ANGLE_W-1:0] angle,
    output logic                      job_valid,
    input  wire logic                 job_ready,
    output sct_pkg::sct_job_t         job
);
    logic        s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic        s1_cos_reg, s1_neg_reg, s2_cos_reg;
    logic [39:0] s1_mag_reg;
    logic [63:0] s1_q_reg;
    logic signed [63:0] s2_r_reg;
    sct_pkg::sct_job_t s3_job_reg, s3_job_next;
    logic        adv1, adv2, adv3;
    logic [39:0] mag;
    logic [63:0] prod, qc, mag56, rem, q;
    logic signed [63:0] r, f;
    logic        neg;

    assign adv3 = !s3_valid_reg || job_ready;
    assign adv2 = !s2_valid_reg || adv3;
    assign adv1 = !s1_valid_reg || adv2;
    assign in_ready = adv1;
    assign job_valid = s3_valid_reg;
    assign job = s3_job_reg;

    always_comb
    begin
        neg  = angle[sct_pkg::ANGLE_W-1];
        mag  = neg ? 40'(-angle) : angle;
        prod = 64'({24'd0, mag} * {40'd0, sct_pkg::INV_TWO_PI_Q24});
    end

    // Stage two: exact floor quotient by one correction each way.
    always_comb
    begin
        mag56 = {s1_mag_reg, 24'd0};
        q     = s1_q_reg;
        qc    = q * 64'(sct_pkg::TWO_PI_Q56);
        if (q != 64'd0 && qc > mag56)
        begin
            q  = q - 64'd1;
            qc = qc - 64'(sct_pkg::TWO_PI_Q56);
        end
        rem = mag56 - qc;
        if (rem >= 64'(sct_pkg::TWO_PI_Q56))
            rem = rem - 64'(sct_pkg::TWO_PI_Q56);
        r = s1_neg_reg ? -$signed(rem) : $signed(rem);
        if (r > sct_pkg::PI_Q56)
            r = r - sct_pkg::TWO_PI_Q56;
        else if (r < -sct_pkg::PI_Q56)
            r = r + sct_pkg::TWO_PI_Q56;
    end

    // Stage three: fold by symmetry and pick the series.
    always_comb
    begin
        f = s2_r_reg;
        s3_job_next = '0;
        if (s2_cos_reg == sct_pkg::REQ_SIN)
        begin
            if (f > sct_pkg::HALF_PI_Q56)
                f = sct_pkg::PI_Q56 - f;
            else if (f < -sct_pkg::HALF_PI_Q56)
                f = -sct_pkg::PI_Q56 - f;
            if (f > sct_pkg::QUARTER_PI_Q56)
            begin
                s3_job_next.cosine = 1'b1;
                s3_job_next.arg    = sct_pkg::HALF_PI_Q56 - f;
            end
            else if (f < -sct_pkg::QUARTER_PI_Q56)
            begin
                s3_job_next.cosine = 1'b1;
                s3_job_next.negate = 1'b1;
                s3_job_next.arg    = sct_pkg::HALF_PI_Q56 + f;
            end
            else
                s3_job_next.arg = f;
        end
        else
        begin
            if (f < 0)
                f = -f;
            if (f > sct_pkg::HALF_PI_Q56)
            begin
                f = sct_pkg::PI_Q56 - f;
                s3_job_next.negate = 1'b1;
            end
            if (f > sct_pkg::QUARTER_PI_Q56)
                s3_job_next.arg = sct_pkg::HALF_PI_Q56 - f;
            else
            begin
                s3_job_next.cosine = 1'b1;
                s3_job_next.arg    = f;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1) s1_valid_reg <= in_valid;
            if (adv2) s2_valid_reg <= s1_valid_reg;
            if (adv3) s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            s1_mag_reg <= mag;
            s1_q_reg   <= prod >> 56;
            s1_neg_reg <= neg;
            s1_cos_reg <= req_type;
        end
        if (adv2 && s1_valid_reg)
        begin
            s2_r_reg   <= r;
            s2_cos_reg <= s1_cos_reg;
        end
        if (adv3 && s2_valid_reg)
            s3_job_reg <= s3_job_next;
    end
endmodule
`default_nettype wire

FILE: hw/rtl/sct_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sct_fifo: short job queue
// Two-entry queue that decouples the front part from the series part.
// ----------------------------------------------------------------------------
module sct_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_valid,
    output logic                   wr_ready,
    input  wire sct_pkg::sct_job_t wr_data,
    output logic                   rd_valid,
    input  wire logic              rd_ready,
    output sct_pkg::sct_job_t      rd_data
);
    sct_pkg::sct_job_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data  = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr) wp_reg <= ~wp_reg;
            if (rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_data;
    end
endmodule
`default_nettype wire

FILE: hw/rtl/sct_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sct_back: Taylor series pipeline
// One stage squares the argument, then two stages per series term
// (multiply by x^2, multiply by the reciprocal), then output rounding.
// ----------------------------------------------------------------------------
module sct_back #(
    parameter int MAX_TERMS = 10
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [sct_pkg::TERMS_W-1:0] num_terms,
    input  wire logic              job_valid,
    output logic                   job_ready,
    input  wire sct_pkg::sct_job_t job,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [sct_pkg::VALUE_W-1:0] value
);
    // Load stage, squaring stage, two stages per term, output register.
    localparam int NST = 2 * MAX_TERMS + 3;

    logic               v_reg     [NST];
    logic               cos_reg   [NST];
    logic               cos_next  [NST];
    logic               neg_reg   [NST];
    logic               neg_next  [NST];
    logic signed [33:0] xsq_reg   [NST];
    logic signed [33:0] xsq_next  [NST];
    logic signed [33:0] term_reg  [NST];
    logic signed [33:0] term_next [NST];
    logic signed [33:0] sum_reg   [NST];
    logic signed [33:0] sum_next  [NST];
    logic signed [33:0] t_reg     [NST];
    logic signed [33:0] t_next    [NST];
    logic signed [33:0] x_reg;
    logic [32:0] recip_cos [MAX_TERMS];
    logic [32:0] recip_sin [MAX_TERMS];
    logic [sct_pkg::TERMS_W-1:0] terms;
    logic adv;
    logic signed [95:0] x0;
    logic signed [95:0] prod;
    logic [32:0]        recip;
    logic signed [33:0] res, v;
    logic signed [95:0] vr;

    // Reciprocals of the series divisors, Q0.32 rounded to nearest.
    for (genvar g = 0; g < MAX_TERMS; g++)
    begin : g_recip
        localparam longint unsigned DC = 64'((2 * g + 1) * (2 * g + 2));
        localparam longint unsigned DS = 64'((2 * g + 2) * (2 * g + 3));
        localparam logic [32:0] RC = 33'(((64'd1 << 32) + DC / 64'd2) / DC);
        localparam logic [32:0] RS = 33'(((64'd1 << 32) + DS / 64'd2) / DS);
        assign recip_cos[g] = RC;
        assign recip_sin[g] = RS;
    end

    assign terms = (int'(num_terms) > MAX_TERMS) ?
                   sct_pkg::TERMS_W'(MAX_TERMS) : num_terms;
    // Stall the whole series pipe when the result register is held.
    assign adv = !v_reg[NST-1] || out_ready;
    assign job_ready = adv;
    assign out_valid = v_reg[NST-1];
    assign x0 = sct_pkg::rnd_shift(96'(job.arg), 25);
    assign value = sum_reg[NST-1][31:0];

    always_comb
    begin
        cos_next[0]  = job.cosine;
        neg_next[0]  = job.negate;
        term_next[0] = job.cosine ? sct_pkg::ONE_Q31 : x0[33:0];
        sum_next[0]  = job.cosine ? sct_pkg::ONE_Q31 : x0[33:0];
        xsq_next[0]  = '0;
        t_next[0]    = '0;
        for (int i = 1; i < NST; i++)
        begin
            cos_next[i]  = cos_reg[i-1];
            neg_next[i]  = neg_reg[i-1];
            xsq_next[i]  = xsq_reg[i-1];
            term_next[i] = term_reg[i-1];
            sum_next[i]  = sum_reg[i-1];
            t_next[i]    = t_reg[i-1];
        end
        prod = sct_pkg::rnd_shift(96'(x_reg) * 96'(x_reg), 31);
        xsq_next[1] = prod[33:0];
        for (int n = 0; n < MAX_TERMS; n++)
        begin
            prod = sct_pkg::rnd_shift(96'(term_reg[2*n+1]) * 96'(xsq_reg[2*n+1]), 31);
            t_next[2*n+2] = prod[33:0];
            recip = cos_reg[2*n+2] ? recip_cos[n] : recip_sin[n];
            prod = -sct_pkg::rnd_shift(96'(t_reg[2*n+2]) * 96'(recip), 32);
            if (n < int'(terms))
            begin
                term_next[2*n+3] = prod[33:0];
                sum_next[2*n+3]  = sum_reg[2*n+2] + prod[33:0];
            end
        end
        res = neg_reg[NST-2] ? -sum_reg[NST-2] : sum_reg[NST-2];
        vr  = sct_pkg::rnd_shift(96'(res), 1);
        v   = vr[33:0];
        if (v > sct_pkg::OUT_LIMIT)
            v = sct_pkg::OUT_LIMIT;
        else if (v < -sct_pkg::OUT_LIMIT)
            v = -sct_pkg::OUT_LIMIT;
        // The final stage holds the rounded result.
        sum_next[NST-1] = v;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NST; i++)
                v_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= job_valid;
            for (int i = 1; i < NST; i++)
                v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg <= x0[33:0];
            for (int i = 0; i < NST; i++)
            begin
                cos_reg[i]  <= cos_next[i];
                neg_reg[i]  <= neg_next[i];
                xsq_reg[i]  <= xsq_next[i];
                term_reg[i] <= term_next[i];
                sum_reg[i]  <= sum_next[i];
                t_reg[i]    <= t_next[i];
            end
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/sine_cosine_taylor_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sine_cosine_taylor_unit: sine or cosine by range reduction and Taylor series
// Takes a Q8.32 angle and a selector, returns sine or cosine in Q2.30.
// ----------------------------------------------------------------------------
// One word is accepted per cycle and one result leaves per cycle in steady
// state, unless the result channel stalls. The path holds three stages of
// range reduction and folding, a two-entry queue, a load stage, a squaring
// stage, two multiply stages per series term and the output register.
// num_terms may be written only while the unit is empty.
module sine_cosine_taylor_unit #(
    parameter int MAX_TERMS = 10
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic [sct_pkg::TERMS_W-1:0] cfg_wdata,
    sct_in_if.sink    req,
    sct_out_if.source rsp
);
    logic [sct_pkg::TERMS_W-1:0] num_terms_reg;
    logic f_valid, f_ready, q_valid, q_ready;
    sct_pkg::sct_job_t f_job, q_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            num_terms_reg <= sct_pkg::TERMS_W'(10);
        else if (cfg_we)
            num_terms_reg <= cfg_wdata;
    end

    sct_front u_front (
        .clk, .rst_n,
        .in_valid(req.valid), .in_ready(req.ready),
        .req_type(req.req_type), .angle(req.angle),
        .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
    );

    sct_fifo u_fifo (
        .clk, .rst_n,
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_job)
    );

    sct_back #(.MAX_TERMS(MAX_TERMS)) u_back (
        .clk, .rst_n, .num_terms(num_terms_reg),
        .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
        .out_valid(rsp.valid), .out_ready(rsp.ready), .value(rsp.value)
    );
endmodule
`default_nettype wire

FILE: hw/rtl/sct_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sct_checker: port checks for the sine and cosine unit
// Checks the output channel and result range.
// ----------------------------------------------------------------------------
module sct_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic [31:0] value
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(value)) else $error("result changed");
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed(value) <= 32'sh40000000 &&
                       $signed(value) >= -32'sh40000000))
        else $error("result out of range");
endmodule

bind sine_cosine_taylor_unit sct_checker u_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(rsp.valid),
    .out_ready(rsp.ready), .value(rsp.value)
);
`default_nettype wire

FILE: sim/tb_sine_cosine_taylor_unit.sv
// ----------------------------------------------------------------------------
// tb_sine_cosine_taylor_unit: self-checking bench for the sine and cosine unit
// Drives angle and selector words through the request channel under several
// idle and stall patterns. Each result is checked against a given value or a
// fixed-point predictor of range reduction, folding and the Taylor series, for
// several term counts written between phases.
// ----------------------------------------------------------------------------
module tb_sine_cosine_taylor_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = 2 * 10 + 7;
    localparam int CYCLE_CAP = 400000;

    typedef struct {
        logic              sel;
        logic signed [39:0] ang;
        logic              has_value;
        logic signed [31:0] value;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [3:0] cfg_wdata;

    sct_in_if  req();
    sct_out_if rsp();

    sine_cosine_taylor_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp       (rsp)
    );

    logic signed [31:0] expected_values[$];
    int unsigned        terms_setting;
    int                 errors;
    int                 cycles;
    int                 send_idle_pct;
    int                 recv_stall_pct;
    stim_row_t          directed_rows[$];

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles = cycles + 1;
            if (cycles > CYCLE_CAP)
            begin
                $display("FAIL sine_cosine_taylor_unit");
                $finish;
            end
        end
    end

    function automatic longint round_shift(input longint v, input int sh);
        longint unsigned m;
        begin
            m = v < 0 ? -v : v;
            m = (m + (64'd1 << (sh - 1))) >> sh;
            return v < 0 ? -longint'(m) : longint'(m);
        end
    endfunction

    // Angle in Q8.32 to a remainder in Q.56 within [-pi, pi].
    function automatic longint reduce_angle(input logic signed [39:0] ang);
        logic [39:0]     mag;
        longint unsigned mag56;
        longint unsigned q;
        longint unsigned rem;
        logic [87:0]     prod;
        longint          r;
        begin
            mag   = ang[39] ? -ang : ang;
            mag56 = 64'(mag) << 24;
            prod  = 88'(mag) * 88'(sct_pkg::INV_TWO_PI_Q24);
            q     = 64'(prod >> 56);
            if (q > 0 && q * sct_pkg::TWO_PI_Q56 > mag56)
                q = q - 1;
            rem = mag56 - q * sct_pkg::TWO_PI_Q56;
            if (rem >= sct_pkg::TWO_PI_Q56)
                rem = rem - sct_pkg::TWO_PI_Q56;
            r = ang[39] ? -longint'(rem) : longint'(rem);
            if (r > sct_pkg::PI_Q56)
                r = r - sct_pkg::TWO_PI_Q56;
            else if (r < -sct_pkg::PI_Q56)
                r = r + sct_pkg::TWO_PI_Q56;
            return r;
        end
    endfunction

    function automatic longint taylor_sum(input longint a56, input logic cosine,
                                          input int unsigned terms);
        longint          x;
        longint          xsq;
        longint          term;
        longint          sum;
        longint          t;
        longint unsigned d;
        longint          recip;
        begin
            x    = round_shift(a56, 25);
            xsq  = round_shift(x * x, 31);
            term = cosine ? 64'sd1 <<< 31 : x;
            sum  = term;
            for (int n = 0; n < terms; n++)
            begin
                d = cosine ? (2 * n + 1) * (2 * n + 2) : (2 * n + 2) * (2 * n + 3);
                recip = longint'(((64'd1 << 32) + d / 2) / d);
                t = round_shift(term * xsq, 31);
                term = -round_shift(t * recip, 32);
                sum = sum + term;
            end
            return sum;
        end
    endfunction

    function automatic logic signed [31:0] predict_value(input logic sel,
                                                         input logic signed [39:0] ang);
        int unsigned terms;
        longint      r;
        longint      res;
        longint      v;
        logic        flip;
        begin
            terms = terms_setting > 10 ? 10 : terms_setting;
            r = reduce_angle(ang);
            flip = 1'b0;
            if (sel == sct_pkg::REQ_SIN)
            begin
                if (r > sct_pkg::HALF_PI_Q56)
                    r = sct_pkg::PI_Q56 - r;
                else if (r < -sct_pkg::HALF_PI_Q56)
                    r = -sct_pkg::PI_Q56 - r;
                if (r > sct_pkg::QUARTER_PI_Q56)
                    res = taylor_sum(sct_pkg::HALF_PI_Q56 - r, 1'b1, terms);
                else if (r < -sct_pkg::QUARTER_PI_Q56)
                    res = -taylor_sum(sct_pkg::HALF_PI_Q56 + r, 1'b1, terms);
                else
                    res = taylor_sum(r, 1'b0, terms);
            end
            else
            begin
                if (r < 0)
                    r = -r;
                if (r > sct_pkg::HALF_PI_Q56)
                begin
                    r = sct_pkg::PI_Q56 - r;
                    flip = 1'b1;
                end
                if (r > sct_pkg::QUARTER_PI_Q56)
                    res = taylor_sum(sct_pkg::HALF_PI_Q56 - r, 1'b0, terms);
                else
                    res = taylor_sum(r, 1'b1, terms);
                if (flip)
                    res = -res;
            end
            v = round_shift(res, 1);
            if (v > sct_pkg::OUT_LIMIT)
                v = sct_pkg::OUT_LIMIT;
            else if (v < -sct_pkg::OUT_LIMIT)
                v = -sct_pkg::OUT_LIMIT;
            return v[31:0];
        end
    endfunction

    // Result side: random stall, then compare each accepted word.
    initial
    begin
        rsp.ready = 1'b0;
        errors = 0;
        forever
        begin
            @(negedge clk);
            rsp.ready = ($urandom_range(99) >= recv_stall_pct);
            @(posedge clk);
            if (rst_n && rsp.valid && rsp.ready)
            begin
                if (expected_values.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, rsp.value);
                    errors = errors + 1;
                end
                else if (rsp.value !== expected_values[0])
                begin
                    $display("%0t: value expected %h actual %h", $time,
                             expected_values[0], rsp.value);
                    errors = errors + 1;
                    void'(expected_values.pop_front());
                end
                else
                    void'(expected_values.pop_front());
            end
        end
    end

    task automatic send_angle(input logic sel, input logic signed [39:0] ang,
                              input logic has_value, input logic signed [31:0] value);
        begin
            while ($urandom_range(99) < send_idle_pct)
                @(negedge clk);
            req.valid    = 1'b1;
            req.req_type = sel;
            req.angle    = ang;
            @(posedge clk);
            while (!req.ready)
                @(posedge clk);
            expected_values.push_back(has_value ? value : predict_value(sel, ang));
            @(negedge clk);
            req.valid = 1'b0;
        end
    endtask

    task automatic drain_and_write(input logic [3:0] terms);
        begin
            while (expected_values.size() != 0)
                @(negedge clk);
            repeat (LATENCY) @(negedge clk);
            cfg_we = 1'b1;
            cfg_wdata = terms;
            @(negedge clk);
            cfg_we = 1'b0;
            terms_setting = terms;
        end
    endtask

    task automatic random_angles(input int count);
        logic signed [39:0] ang;
        begin
            for (int i = 0; i < count; i++)
            begin
                case ($urandom_range(3))
                    0: ang = 40'({$urandom, $urandom});
                    1: ang = 40'($signed($urandom_range(32'h3243F6A8))) - 40'sh3243F6A8
                             + 40'($signed($urandom_range(32'h3243F6A8)));
                    2: ang = 40'sh7F_FFFF_FFFF - 40'($urandom_range(1000)) * 40'h1_0000_0000
                             - 40'($urandom);
                    default: ang = -40'sh80_0000_0000 + 40'($urandom);
                endcase
                send_angle(1'($urandom_range(1)), ang, 1'b0, '0);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req.valid = 1'b0;
        req.req_type = sct_pkg::REQ_SIN;
        req.angle = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        terms_setting = 10;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Zero, the extremes, near pi/4, pi/2, pi and 2*pi boundaries.
        directed_rows = '{
            '{sct_pkg::REQ_SIN, 40'sd0,             1'b1, 32'sd0},
            '{sct_pkg::REQ_COS, 40'sd0,             1'b0, 32'sd0},
            '{sct_pkg::REQ_SIN, 40'sh7F_FFFF_FFFF,  1'b0, 32'sd0},
            '{sct_pkg::REQ_COS, 40'sh7F_FFFF_FFFF,  1'b0, 32'sd0},
            '{sct_pkg::REQ_SIN, -40'sh80_0000_0000, 1'b0, 32'sd0},
            '{sct_pkg::REQ_COS, -40'sh80_0000_0000, 1'b0, 32'sd0},
            '{sct_pkg::REQ_SIN, 40'sh0_C90F_DAA2,   1'b0, 32'sd0},
            '{sct_pkg::REQ_COS, 40'sh0_C90F_DAA3,   1'b0, 32'sd0},
            '{sct_pkg::REQ_SIN, 40'sh1_921F_B544,   1'b0, 32'sd0},
            '{sct_pkg::REQ_COS, -40'sh1_921F_B545,  1'b0, 32'sd0},
            '{sct_pkg::REQ_SIN, 40'sh3_243F_6A88,   1'b0, 32'sd0},
            '{sct_pkg::REQ_COS, -40'sh3_243F_6A89,  1'b0, 32'sd0},
            '{sct_pkg::REQ_SIN, 40'sh6_487E_D511,   1'b0, 32'sd0},
            '{sct_pkg::REQ_COS, 40'sh6_487E_D511,   1'b0, 32'sd0},
            '{sct_pkg::REQ_SIN, -40'sh2_5B2F_8FE6,  1'b0, 32'sd0},
            '{sct_pkg::REQ_COS, 40'sh4_B65F_1FCC,   1'b0, 32'sd0},
            '{sct_pkg::REQ_SIN, 40'sd1,             1'b0, 32'sd0},
            '{sct_pkg::REQ_COS, -40'sd1,            1'b0, 32'sd0}
        };
        foreach (directed_rows[i])
            send_angle(directed_rows[i].sel, directed_rows[i].ang,
                       directed_rows[i].has_value, directed_rows[i].value);

        // Zero terms: cosine is exactly one.
        drain_and_write(4'd0);
        send_angle(sct_pkg::REQ_COS, 40'sd0, 1'b1, 32'sh4000_0000);
        send_angle(sct_pkg::REQ_SIN, 40'sh0_4000_0000, 1'b0, '0);
        random_angles(60);

        drain_and_write(4'd15);
        send_idle_pct = 62;
        random_angles(120);

        drain_and_write(4'd3);
        send_idle_pct = 0;
        recv_stall_pct = 62;
        random_angles(120);

        drain_and_write(4'd10);
        send_idle_pct = 20;
        recv_stall_pct = 20;
        random_angles(120);

        drain_and_write(4'd1);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_angles(110);

        while (expected_values.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
        if (errors == 0)
            $display("PASS sine_cosine_taylor_unit");
        else
            $display("FAIL sine_cosine_taylor_unit");
        $finish;
    end
endmodule

FILE: sine_cosine_taylor_unit.f
hw/rtl/sct_pkg.sv
hw/rtl/sct_if.sv
hw/rtl/sct_front.sv
hw/rtl/sct_fifo.sv
hw/rtl/sct_back.sv
hw/rtl/sine_cosine_taylor_unit.sv
hw/rtl/sct_checker.sv
sim/tb_sine_cosine_taylor_unit.sv
